// ===== hdl/chd_pkg.sv =====
// ----------------------------------------------------------------------------
// chd_pkg: shared types and constants of the canonical Huffman bit decoder
// Request codes, fixed field widths, decode state and per-bit result types.
// ----------------------------------------------------------------------------
`default_nettype none

package chd_pkg;

   // Default sizing of the code table.
   localparam int MAX_CODE_LENGTH_DEF = 16;
   localparam int MAX_SYMBOLS_DEF     = 256;

   // Fixed widths set by the item fields and the decode arithmetic.
   localparam int NUM_LENGTHS = 16;
   localparam int LIDX_W      = 4;
   localparam int VALUE_W     = 8;
   localparam int PREFIX_W    = 16;
   localparam int PLEN_W      = 5;
   localparam int FIRST_W     = 17;
   localparam int BASE_W      = 12;
   localparam int IDX_W       = 17;

   // Request codes carried in req_type.
   typedef enum logic [1:0] {
      REQ_LOAD_COUNT = 2'd0,
      REQ_APPEND     = 2'd1,
      REQ_DECODE     = 2'd2,
      REQ_UNUSED     = 2'd3
   } req_code_type;

   // One accepted input beat.
   typedef struct packed {
      logic [1:0]         req_type;
      logic [LIDX_W-1:0]  length_index;
      logic [VALUE_W-1:0] load_value;
      logic               stream_bit;
   } item_type;

   // Canonical decode state: current prefix and its length, and the first code
   // and symbol base of the next longer length.
   typedef struct packed {
      logic [PREFIX_W-1:0] prefix;
      logic [PLEN_W-1:0]   plen;
      logic [FIRST_W-1:0]  first;
      logic [BASE_W-1:0]   base;
   } dec_state_type;

   // Outcome of one stream bit.
   typedef struct packed {
      logic              fire;
      logic              no_match;
      logic              in_range;
      logic [PLEN_W-1:0] code_bits;
   } step_result_type;

endpackage

`default_nettype wire

// ===== hdl/chd_ifs.sv =====
// ----------------------------------------------------------------------------
// chd_ifs: request and response channels of the Huffman bit decoder
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface chd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [3:0] length_index;
   logic [7:0] load_value;
   logic       stream_bit;

   modport source (output valid, output req_type, output length_index,
                   output load_value, output stream_bit, input ready);
   modport sink   (input valid, input req_type, input length_index,
                   input load_value, input stream_bit, output ready);
endinterface

interface chd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic [4:0] code_bits;
   logic       no_match;

   modport source (output valid, output symbol, output code_bits,
                   output no_match, input ready);
   modport sink   (input valid, input symbol, input code_bits,
                   input no_match, output ready);
endinterface

`default_nettype wire

// ===== hdl/chd_ram.sv =====
// ----------------------------------------------------------------------------
// chd_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds when not enabled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/chd_len_table.sv =====
// ----------------------------------------------------------------------------
// chd_len_table: code length counts and weighted suffix sums
// Holds the count of codewords per length and, for every length p, the sum
// of count[i] * 2^(MAX_CODE_LENGTH-1-i) over i >= p, kept up to date by an
// incremental update on each count load.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_len_table
   import chd_pkg::*;
#(
   parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic [LIDX_W-1:0]            wr_value_index,
   input  wire logic [VALUE_W-1:0]           wr_value,
   input  wire logic [LIDX_W-1:0]            rd_index,
   output      logic [VALUE_W-1:0]           rd_count,
   input  wire logic [LIDX_W-1:0]            sum_index,
   output      logic [VALUE_W+MAX_CODE_LENGTH-1:0] sum_value
);

   localparam int SUM_W = VALUE_W + MAX_CODE_LENGTH;

   logic [VALUE_W-1:0] counts_ff [NUM_LENGTHS];
   logic [VALUE_W-1:0] counts_in [NUM_LENGTHS];
   logic [SUM_W-1:0]   sums_ff   [NUM_LENGTHS];
   logic [SUM_W-1:0]   sums_in   [NUM_LENGTHS];
   logic [VALUE_W:0]   delta;
   logic [PLEN_W-1:0]  weight_shift;
   logic [SUM_W-1:0]   weight_step;

   // The single read port serves the old count on a load and the current
   // length's count on a decode; the two never occur together.
   assign rd_count  = counts_ff[rd_index];
   assign sum_value = sums_ff[sum_index];

   // Change of the weighted sums caused by replacing one count.
   always_comb begin
      delta        = {1'b0, wr_value} - {1'b0, rd_count};
      weight_shift = PLEN_W'(MAX_CODE_LENGTH - 1) - {1'b0, wr_value_index};
      weight_step  = {{(SUM_W-VALUE_W-1){delta[VALUE_W]}}, delta} << weight_shift;
   end

   // Next counts and suffix sums.
   always_comb begin
      counts_in = counts_ff;
      sums_in   = sums_ff;
      if (wr_en) begin
         counts_in[wr_value_index] = wr_value;
         if ({1'b0, wr_value_index} < PLEN_W'(MAX_CODE_LENGTH)) begin
            for (int p = 0; p < NUM_LENGTHS; p++) begin
               if (LIDX_W'(p) <= wr_value_index) begin
                  sums_in[p] = sums_ff[p] + weight_step;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_LENGTHS; p++) begin
            counts_ff[p] <= '0;
            sums_ff[p]   <= '0;
         end
      end else begin
         counts_ff <= counts_in;
         sums_ff   <= sums_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/chd_bit_step.sv =====
// ----------------------------------------------------------------------------
// chd_bit_step: one canonical decode step
// Shifts a stream bit into the prefix, checks it against the codewords of
// its length, detects a prefix that no longer codeword begins with, and
// forms the next decode state.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_bit_step
   import chd_pkg::*;
#(
   parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF,
   parameter int MAX_SYMBOLS     = MAX_SYMBOLS_DEF
) (
   input  wire dec_state_type                      cur_state,
   input  wire logic                               stream_bit,
   input  wire logic [VALUE_W-1:0]                 count,
   input  wire logic [VALUE_W+MAX_CODE_LENGTH-1:0] suffix_sum,
   output      dec_state_type                      next_state,
   output      step_result_type                    result,
   output      logic [$clog2(MAX_SYMBOLS)-1:0]     symbol_addr
);

   localparam int SHIFT_W = PREFIX_W + MAX_CODE_LENGTH;
   localparam int ADDR_W  = $clog2(MAX_SYMBOLS);

   logic [PREFIX_W-1:0] prefix_new;
   logic [PLEN_W-1:0]   plen_new;
   logic [FIRST_W:0]    end_code;
   logic [FIRST_W:0]    prefix_ext;
   logic                hit;
   logic [IDX_W-1:0]    offset;
   logic [IDX_W-1:0]    idx;
   logic [PREFIX_W-1:0] gap;
   logic [PLEN_W-1:0]   scale;
   logic [SHIFT_W-1:0]  gap_scaled;
   logic                dead;
   logic                fail;

   // Extend the prefix and test it against the codewords of this length.
   always_comb begin
      prefix_new = {cur_state.prefix[PREFIX_W-2:0], stream_bit};
      plen_new   = cur_state.plen + PLEN_W'(1);
      prefix_ext = (FIRST_W+1)'(prefix_new);
      end_code   = {1'b0, cur_state.first} + (FIRST_W+1)'(count);
      hit        = (prefix_ext >= {1'b0, cur_state.first}) && (prefix_ext < end_code);
      offset     = IDX_W'(prefix_new) - IDX_W'(cur_state.first);
      idx        = IDX_W'(cur_state.base) + offset;
   end

   // A prefix past the codewords of its length is dead once the number of
   // prefixes that longer codewords use, ceil(sum / 2^scale), is reached;
   // compare gap * 2^scale against the sum instead.
   always_comb begin
      gap        = prefix_new - end_code[PREFIX_W-1:0];
      scale      = PLEN_W'(MAX_CODE_LENGTH) - plen_new;
      gap_scaled = SHIFT_W'(gap) << scale;
      dead       = gap_scaled >= SHIFT_W'(suffix_sum);
      fail       = (plen_new >= PLEN_W'(MAX_CODE_LENGTH)) || (prefix_ext < end_code) || dead;
   end

   // Result of this bit and the state left for the next one.
   always_comb begin
      result.fire      = hit || fail;
      result.no_match  = !hit;
      result.in_range  = hit && (idx < IDX_W'(MAX_SYMBOLS));
      result.code_bits = plen_new;
      symbol_addr      = idx[ADDR_W-1:0];
      if (hit || fail) begin
         next_state = '0;
      end else begin
         next_state.prefix = prefix_new;
         next_state.plen   = plen_new;
         next_state.first  = {end_code[FIRST_W-2:0], 1'b0};
         next_state.base   = cur_state.base + BASE_W'(count);
      end
   end

endmodule

`default_nettype wire

// ===== hdl/canonical_huffman_bit_decoder.sv =====
// ----------------------------------------------------------------------------
// canonical_huffman_bit_decoder: canonical Huffman decoder, one bit per beat
// Loads a JPEG-style table (counts per length, then symbols in code order)
// and decodes a stream one bit per request beat.
// ----------------------------------------------------------------------------
// The block takes one request beat in every clock cycle, whatever its kind,
// as long as the response side keeps up. A decode bit is evaluated while it
// sits in the input register, where the symbol RAM read is issued, and its
// response then passes through stage two and is offered from an output register.
// The figure of one beat per cycle is set by the single decode step from
// the input register to the decode state register and the symbol RAM read,
// which needs two table lookups, one add for the end of the code range, the
// range compares, and a subtract, shift and compare for the dead prefix
// test. There is no clearing pass after reset; symbol entries that were
// never appended read as unknown values.
// ----------------------------------------------------------------------------
`default_nettype none

module canonical_huffman_bit_decoder
   import chd_pkg::*;
#(
   parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF,
   parameter int MAX_SYMBOLS     = MAX_SYMBOLS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   chd_req_if.sink    req_ch,
   chd_rsp_if.source  rsp_ch
);

   localparam int SUM_W  = VALUE_W + MAX_CODE_LENGTH;
   localparam int ADDR_W = $clog2(MAX_SYMBOLS);
   localparam int PTR_W  = ADDR_W + 1;

   // Pipeline registers.
   logic            s1_valid_ff, s1_valid_in;
   item_type        s1_item_ff, s1_item_in;
   logic            s2_valid_ff, s2_valid_in;
   step_result_type s2_res_ff, s2_res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_symbol_ff, rsp_symbol_in;
   logic [4:0]      rsp_length_ff, rsp_length_in;
   logic            rsp_no_match_ff, rsp_no_match_in;

   // Decoder state.
   dec_state_type   dec_ff, dec_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;

   // Handshake and datapath signals.
   logic            out_free, s2_adv, s2_free, s1_adv, s1_free;
   logic            is_load, is_append, is_decode;
   logic            tbl_wr_en;
   logic [LIDX_W-1:0] tbl_rd_index;
   logic [VALUE_W-1:0] tbl_count;
   logic [SUM_W-1:0]  tbl_sum;
   dec_state_type   step_next;
   step_result_type step_res;
   logic [ADDR_W-1:0] step_addr;
   logic            ram_wr_en, ram_rd_en;
   logic [VALUE_W-1:0] ram_rd_data;

   // Stage flow: a stage moves when the one after it is empty or moving.
   always_comb begin
      out_free = !rsp_valid_ff || rsp_ch.ready;
      s2_adv   = s2_valid_ff && out_free;
      s2_free  = !s2_valid_ff || out_free;
      s1_adv   = s1_valid_ff && s2_free;
      s1_free  = !s1_valid_ff || s2_free;
   end

   // No beat is taken while reset is held.
   assign req_ch.ready = s1_free && !reset;

   // Request decoding of the beat held in the input register.
   always_comb begin
      is_load   = s1_adv && (s1_item_ff.req_type == REQ_LOAD_COUNT);
      is_append = s1_adv && (s1_item_ff.req_type == REQ_APPEND);
      is_decode = s1_adv && (s1_item_ff.req_type == REQ_DECODE);
   end

   // Input register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (s1_free) begin
         s1_valid_in             = req_ch.valid;
         s1_item_in.req_type     = req_ch.req_type;
         s1_item_in.length_index = req_ch.length_index;
         s1_item_in.load_value   = req_ch.load_value;
         s1_item_in.stream_bit   = req_ch.stream_bit;
      end
   end

   // Length table: the read port gives the old count on a load.
   assign tbl_wr_en    = is_load;
   assign tbl_rd_index = (s1_item_ff.req_type == REQ_LOAD_COUNT) ?
                         s1_item_ff.length_index : dec_ff.plen[LIDX_W-1:0];

   chd_len_table #(
      .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
   ) u_len_table (
      .clock          (clock),
      .reset          (reset),
      .wr_en          (tbl_wr_en),
      .wr_value_index (s1_item_ff.length_index),
      .wr_value       (s1_item_ff.load_value),
      .rd_index       (tbl_rd_index),
      .rd_count       (tbl_count),
      .sum_index      (dec_ff.plen[LIDX_W-1:0] + LIDX_W'(1)),
      .sum_value      (tbl_sum)
   );

   chd_bit_step #(
      .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
      .MAX_SYMBOLS     (MAX_SYMBOLS)
   ) u_bit_step (
      .cur_state   (dec_ff),
      .stream_bit  (s1_item_ff.stream_bit),
      .count       (tbl_count),
      .suffix_sum  (tbl_sum),
      .next_state  (step_next),
      .result      (step_res),
      .symbol_addr (step_addr)
   );

   // Symbol store: appended in order, read at the decoded index.
   assign ram_wr_en = is_append && (ptr_ff < PTR_W'(MAX_SYMBOLS));
   assign ram_rd_en = is_decode;

   chd_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_SYMBOLS)
   ) u_symbol_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff[ADDR_W-1:0]),
      .wr_data (s1_item_ff.load_value),
      .rd_en   (ram_rd_en),
      .rd_addr (step_addr),
      .rd_data (ram_rd_data)
   );

   // Decode state and append pointer.
   always_comb begin
      dec_in = dec_ff;
      ptr_in = ptr_ff;
      if (is_load && (s1_item_ff.length_index == '0)) begin
         dec_in = '0;
         ptr_in = '0;
      end
      if (ram_wr_en) begin
         ptr_in = ptr_ff + PTR_W'(1);
      end
      if (is_decode) begin
         dec_in = step_next;
      end
   end

   // Stage two waits for the symbol read data.
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_res_in   = s2_res_ff;
      if (s1_adv) begin
         s2_valid_in = is_decode && step_res.fire;
         s2_res_in   = step_res;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_symbol_in   = rsp_symbol_ff;
      rsp_length_in   = rsp_length_ff;
      rsp_no_match_in = rsp_no_match_ff;
      if (out_free) begin
         rsp_valid_in    = s2_valid_ff;
         rsp_symbol_in   = s2_res_ff.in_range ? ram_rd_data : '0;
         rsp_length_in   = s2_res_ff.code_bits;
         rsp_no_match_in = s2_res_ff.no_match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dec_ff       <= '0;
         ptr_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         dec_ff       <= dec_in;
         ptr_ff       <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff      <= s1_item_in;
      s2_res_ff       <= s2_res_in;
      rsp_symbol_ff   <= rsp_symbol_in;
      rsp_length_ff   <= rsp_length_in;
      rsp_no_match_ff <= rsp_no_match_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.symbol    = rsp_symbol_ff;
   assign rsp_ch.code_bits = rsp_length_ff;
   assign rsp_ch.no_match  = rsp_no_match_ff;

endmodule

`default_nettype wire

// ===== tb/tb_canonical_huffman_bit_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_canonical_huffman_bit_decoder: self-checking regression of the decoder
// A short table of directed beats is followed by random table loads and bit
// streams. Directed rows carry their expected results; an in-bench canonical
// decode model predicts the rest, and responses are checked field by field in order of arrival.
// ----------------------------------------------------------------------------

module tb_canonical_huffman_bit_decoder;
   import chd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BEATS = 600;
   localparam int DRAIN_CYCLES = 8;

   // One decoded response as the block should present it.
   typedef struct packed {
      logic [7:0] symbol;
      logic [4:0] code_bits;
      logic       no_match;
   } decoded_type;

   // Outcome of one stream bit and the decode state it leaves behind.
   typedef struct {
      bit          fire;
      bit          unwritten;
      decoded_type res;
      int unsigned prefix;
      int unsigned plen;
      int unsigned first;
      int unsigned base;
   } bit_outcome_type;

   // One row of the directed table.
   typedef struct {
      item_type    beat;
      bit          typed;
      decoded_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   chd_req_if req_ch ();
   chd_rsp_if rsp_ch ();

   canonical_huffman_bit_decoder u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Model copy of the code table and of the canonical decode state.
   logic [7:0]  len_count   [NUM_LENGTHS];
   logic [7:0]  sym_store   [MAX_SYMBOLS_DEF];
   bit          sym_written [MAX_SYMBOLS_DEF];
   int unsigned sym_ptr;
   int unsigned dec_prefix;
   int unsigned dec_plen;
   int unsigned dec_first;
   int unsigned dec_base;

   decoded_type  pending_decodes [$];
   stim_row_type dir_rows [$];
   int unsigned  want_count [NUM_LENGTHS];
   int unsigned  want_total;
   int unsigned  useful_beats = 0;
   int           failures     = 0;
   int           cycle_count  = 0;
   bit           calm         = 1'b0;

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("canonical_huffman_bit_decoder regression: fail");
         $finish;
      end
   end

   // Number of distinct prefixes of length plen that longer codewords begin with.
   function automatic int unsigned longer_prefix_count(int unsigned plen);
      int unsigned n;
      n = 0;
      for (int i = NUM_LENGTHS - 1; i >= int'(plen); i--)
         n = (len_count[i] + n + 1) >> 1;
      return n;
   endfunction

   // Work out what one stream bit does, without committing the state.
   function automatic bit_outcome_type decode_step(logic b);
      bit_outcome_type o;
      int unsigned     cnt;
      int unsigned     end_code;
      int unsigned     idx;
      o.fire      = 1'b0;
      o.unwritten = 1'b0;
      o.res       = '0;
      o.prefix    = ((dec_prefix << 1) | b) & 32'hFFFF;
      o.plen      = dec_plen + 1;
      o.first     = dec_first;
      o.base      = dec_base;
      cnt         = len_count[(o.plen - 1) & (NUM_LENGTHS - 1)];
      end_code    = dec_first + cnt;
      o.res.code_bits = 5'(o.plen);
      if (o.prefix >= dec_first && o.prefix < end_code) begin
         idx    = dec_base + (o.prefix - dec_first);
         o.fire = 1'b1;
         if (idx < MAX_SYMBOLS_DEF) begin
            o.res.symbol = sym_store[idx];
            o.unwritten  = !sym_written[idx];
         end
      end else if (o.plen >= MAX_CODE_LENGTH_DEF || o.prefix < end_code ||
                   o.prefix - end_code >= longer_prefix_count(o.plen)) begin
         o.fire         = 1'b1;
         o.res.no_match = 1'b1;
      end else begin
         o.first = (end_code << 1) & 32'h1FFFF;
         o.base  = dec_base + cnt;
      end
      // Any result starts a fresh prefix.
      if (o.fire) begin
         o.prefix = 0;
         o.plen   = 0;
         o.first  = 0;
         o.base   = 0;
      end
      return o;
   endfunction

   // Apply one accepted beat to the model; returns 1 when it yields a result.
   function automatic bit predict_beat(item_type it, output decoded_type r);
      bit_outcome_type o;
      r = '0;
      case (it.req_type)
         REQ_LOAD_COUNT: begin
            len_count[it.length_index] = it.load_value;
            if (it.length_index == '0) begin
               sym_ptr    = 0;
               dec_prefix = 0;
               dec_plen   = 0;
               dec_first  = 0;
               dec_base   = 0;
            end
         end
         REQ_APPEND: begin
            if (sym_ptr < MAX_SYMBOLS_DEF) begin
               sym_store[sym_ptr]   = it.load_value;
               sym_written[sym_ptr] = 1'b1;
               sym_ptr++;
            end
         end
         REQ_DECODE: begin
            o          = decode_step(it.stream_bit);
            dec_prefix = o.prefix;
            dec_plen   = o.plen;
            dec_first  = o.first;
            dec_base   = o.base;
            r          = o.res;
            return o.fire;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic item_type beat_of(logic [1:0] req, logic [3:0] lidx,
                                        logic [7:0] val, logic b);
      item_type it;
      it.req_type     = req;
      it.length_index = lidx;
      it.load_value   = val;
      it.stream_bit   = b;
      return it;
   endfunction

   function automatic stim_row_type stim_row(logic [1:0] req, logic [3:0] lidx,
                                             logic [7:0] val, logic b, bit typed,
                                             logic [7:0] sym, logic [4:0] len,
                                             logic nm);
      stim_row_type row;
      row.beat  = beat_of(req, lidx, val, b);
      row.typed = typed;
      row.want  = '{symbol: sym, code_bits: len, no_match: nm};
      return row;
   endfunction

   // Drive one request beat, wait for it to be taken and record what it yields.
   task automatic send_beat(input item_type it, input bit typed, input decoded_type want);
      bit_outcome_type o;
      decoded_type     r;
      int unsigned     gap;
      bit              fired;
      // A bit that would read a symbol entry never appended is steered away.
      if (it.req_type == REQ_DECODE) begin
         o = decode_step(it.stream_bit);
         if (o.unwritten) begin
            it.stream_bit = ~it.stream_bit;
            o = decode_step(it.stream_bit);
         end
         if (o.unwritten) begin
            it.req_type     = REQ_LOAD_COUNT;
            it.length_index = '0;
            it.load_value   = len_count[0];
         end
      end
      if (it.req_type != REQ_UNUSED &&
          !(it.req_type == REQ_APPEND && sym_ptr >= MAX_SYMBOLS_DEF))
         useful_beats++;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= it.req_type;
      req_ch.length_index <= it.length_index;
      req_ch.load_value   <= it.load_value;
      req_ch.stream_bit   <= it.stream_bit;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      fired = predict_beat(it, r);
      if (typed)
         pending_decodes.push_back(want);
      else if (fired)
         pending_decodes.push_back(r);
   endtask

   task automatic send_plain(input item_type it);
      send_beat(it, 1'b0, '0);
   endtask

   // Stop sending until every predicted result has come back.
   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_decodes.size() != 0);
   endtask

   // Send the canonical codeword of symbol index k, optionally with its last bit flipped.
   task automatic send_codeword(input int unsigned k, input bit flip);
      int unsigned first;
      int unsigned base;
      int unsigned len;
      int unsigned code;
      first = 0;
      base  = 0;
      len   = 0;
      code  = 0;
      for (int l = 0; l < NUM_LENGTHS && len == 0; l++) begin
         if (k < base + len_count[l]) begin
            len  = l + 1;
            code = first + (k - base);
         end else begin
            base  = base + len_count[l];
            first = (first + len_count[l]) << 1;
         end
      end
      if (len == 0) begin
         len  = 1;
         code = $urandom_range(0, 1);
      end
      for (int p = int'(len) - 1; p >= 0; p--)
         send_plain(beat_of(REQ_DECODE, 4'($urandom_range(0, 15)),
                            8'($urandom_range(0, 255)),
                            code[p] ^ (flip && p == 0)));
   endtask

   // Choose a table that is not oversubscribed; deep_count forces a single
   // populated length of 16 bits.
   task automatic pick_table(input int unsigned deep_count);
      int unsigned avail;
      int unsigned lim;
      int unsigned maxlen;
      int unsigned budget;
      int unsigned mode;
      mode = $urandom_range(0, 9);
      want_total = 0;
      for (int i = 0; i < NUM_LENGTHS; i++)
         want_count[i] = 0;
      if (deep_count != 0 || mode == 0) begin
         want_count[NUM_LENGTHS - 1] = (deep_count != 0) ? deep_count : $urandom_range(1, 4);
         want_total = want_count[NUM_LENGTHS - 1];
      end else begin
         maxlen = (mode < 8) ? $urandom_range(1, 8) : $urandom_range(9, 16);
         budget = $urandom_range(1, 24);
         avail  = 2;
         for (int l = 0; l < int'(maxlen); l++) begin
            lim = avail;
            if (lim > 255) lim = 255;
            if (lim > budget - want_total) lim = budget - want_total;
            if (l == int'(maxlen) - 1 && $urandom_range(0, 3) != 0)
               want_count[l] = lim;
            else
               want_count[l] = $urandom_range(0, lim);
            want_total = want_total + want_count[l];
            avail = (avail - want_count[l]) * 2;
            if (avail > 1024) avail = 1024;
         end
      end
   endtask

   // Load the chosen counts (length index 0 first, as it rewinds the symbol
   // pointer), then append nsym random symbol values.
   task automatic load_table(input int unsigned nsym);
      send_plain(beat_of(REQ_LOAD_COUNT, 4'd0, 8'(want_count[0]),
                         1'($urandom_range(0, 1))));
      for (int i = 1; i < NUM_LENGTHS; i++)
         if (len_count[i] != 8'(want_count[i]))
            send_plain(beat_of(REQ_LOAD_COUNT, 4'(i), 8'(want_count[i]),
                               1'($urandom_range(0, 1))));
      for (int unsigned n = 0; n < nsym; n++)
         send_plain(beat_of(REQ_APPEND, 4'($urandom_range(0, 15)),
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
   endtask

   // Response side: random stalls, and every beat checked against the oldest prediction.
   initial begin : rsp_side
      int unsigned n;
      decoded_type exp_res;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         n = calm ? 0 : $urandom_range(0, 3);
         if (n != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         if (pending_decodes.size() == 0) begin
            $display("%0t: unexpected result beat: symbol %h, length %0d, no_match %b",
                     $time, rsp_ch.symbol, rsp_ch.code_bits, rsp_ch.no_match);
            failures++;
         end else begin
            exp_res = pending_decodes.pop_front();
            if (rsp_ch.symbol !== exp_res.symbol) begin
               $display("%0t: symbol: expected %h, actual %h",
                        $time, exp_res.symbol, rsp_ch.symbol);
               failures++;
            end
            if (rsp_ch.code_bits !== exp_res.code_bits) begin
               $display("%0t: code_bits: expected %0d, actual %0d",
                        $time, exp_res.code_bits, rsp_ch.code_bits);
               failures++;
            end
            if (rsp_ch.no_match !== exp_res.no_match) begin
               $display("%0t: no_match: expected %b, actual %b",
                        $time, exp_res.no_match, rsp_ch.no_match);
               failures++;
            end
         end
      end
   end

   // Stimulus.
   initial begin : req_side
      int unsigned scenario;
      int unsigned n_words;
      int unsigned roll;
      int unsigned k;
      bit          big;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.req_type     <= REQ_LOAD_COUNT;
      req_ch.length_index <= '0;
      req_ch.load_value   <= '0;
      req_ch.stream_bit   <= 1'b0;

      // Model reset.
      for (int i = 0; i < NUM_LENGTHS; i++)
         len_count[i] = '0;
      for (int i = 0; i < MAX_SYMBOLS_DEF; i++) begin
         sym_store[i]   = '0;
         sym_written[i] = 1'b0;
      end
      sym_ptr    = 0;
      dec_prefix = 0;
      dec_plen   = 0;
      dec_first  = 0;
      dec_base   = 0;

      // Directed table: empty-table errors, the unused code, a full three-level
      // tree with extreme symbols, then a dead prefix after emptying length 3.
      dir_rows.push_back(stim_row(REQ_DECODE, 4'd0, 8'h00, 1'b0, 1'b1, 8'h00, 5'd1, 1'b1));
      dir_rows.push_back(stim_row(REQ_DECODE, 4'd0, 8'h00, 1'b1, 1'b1, 8'h00, 5'd1, 1'b1));
      dir_rows.push_back(stim_row(REQ_UNUSED, 4'hF, 8'hFF, 1'b1, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_LOAD_COUNT, 4'd0, 8'd1, 1'b0, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_LOAD_COUNT, 4'd1, 8'd1, 1'b0, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_LOAD_COUNT, 4'd2, 8'd2, 1'b0, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_APPEND, 4'd0, 8'h00, 1'b0, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_APPEND, 4'd0, 8'hFF, 1'b0, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_APPEND, 4'd0, 8'h5A, 1'b0, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_APPEND, 4'd0, 8'hA5, 1'b0, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_DECODE, 4'd0, 8'h00, 1'b0, 1'b1, 8'h00, 5'd1, 1'b0));
      dir_rows.push_back(stim_row(REQ_DECODE, 4'd0, 8'h00, 1'b1, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_DECODE, 4'd0, 8'h00, 1'b0, 1'b1, 8'hFF, 5'd2, 1'b0));
      dir_rows.push_back(stim_row(REQ_DECODE, 4'd0, 8'h00, 1'b1, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_DECODE, 4'd0, 8'h00, 1'b1, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_DECODE, 4'd0, 8'h00, 1'b0, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_DECODE, 4'd0, 8'h00, 1'b1, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_DECODE, 4'd0, 8'h00, 1'b1, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_DECODE, 4'd0, 8'h00, 1'b1, 1'b1, 8'hA5, 5'd3, 1'b0));
      dir_rows.push_back(stim_row(REQ_LOAD_COUNT, 4'd2, 8'd0, 1'b0, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_DECODE, 4'd0, 8'h00, 1'b1, 1'b0, '0, '0, 1'b0));
      dir_rows.push_back(stim_row(REQ_DECODE, 4'd0, 8'h00, 1'b1, 1'b1, 8'h00, 5'd2, 1'b1));
      dir_rows.push_back(stim_row(REQ_LOAD_COUNT, 4'hF, 8'hFF, 1'b0, 1'b0, '0, '0, 1'b0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

      // Let the pipeline run dry once before the random part.
      hold_until_drained();
      useful_beats = 0;
      scenario     = 0;

      // Random part: load a table, then stream mostly whole codewords with
      // some noise, loose bits and broken codewords mixed in. The first table
      // has a single 16-bit code and the second fills the symbol store.
      while (useful_beats < RANDOM_BEATS) begin
         calm = ($urandom_range(0, 3) == 0);
         big  = (scenario == 1);
         if (big) begin
            // Full symbol store, with one code whose index lies past its end.
            for (int i = 0; i < NUM_LENGTHS; i++)
               want_count[i] = 0;
            want_count[7] = 255;
            want_count[8] = 2;
            want_total    = 257;
            load_table(MAX_SYMBOLS_DEF + 2);
         end else begin
            pick_table((scenario == 0) ? 1 : 0);
            load_table(want_total);
         end
         n_words = big ? 20 : ((scenario == 0) ? 6 : $urandom_range(8, 30));
         for (int unsigned j = 0; j < n_words && useful_beats < RANDOM_BEATS; j++) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               send_plain(beat_of(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
            end else if (roll < 25) begin
               repeat ($urandom_range(1, 4))
                  send_plain(beat_of(REQ_DECODE, 4'($urandom_range(0, 15)),
                                     8'($urandom_range(0, 255)),
                                     1'($urandom_range(0, 1))));
            end else begin
               if (big)
                  k = $urandom_range(250, 256);
               else
                  k = (want_total == 0) ? 0 : $urandom_range(0, want_total - 1);
               send_codeword(k, $urandom_range(0, 99) < 15);
            end
         end
         if ($urandom_range(0, 2) == 0)
            hold_until_drained();
         scenario++;
      end

      // Wind down: wait for every prediction, then a few idle cycles.
      calm = 1'b0;
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("canonical_huffman_bit_decoder regression: pass");
      else
         $display("canonical_huffman_bit_decoder regression: fail");
      $finish;
   end

endmodule

// ===== canonical_huffman_bit_decoder.f =====
hdl/chd_pkg.sv
hdl/chd_ifs.sv
hdl/chd_ram.sv
hdl/chd_len_table.sv
hdl/chd_bit_step.sv
hdl/canonical_huffman_bit_decoder.sv
tb/tb_canonical_huffman_bit_decoder.sv
